// File: hw/rtl/ich_pkg.sv
// Package for the incremental convex hull unit.
// Holds sizes, item codes, and the request/response types of the shared cross unit.
// No dependencies.
package ich_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int COORD_BITS   = 16;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int VIDX_W       = 8;

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_LOCATE = 2'd1,
        K_READ   = 2'd2,
        K_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        POS_INSIDE  = 2'd0,
        POS_BORDER  = 2'd1,
        POS_OUTSIDE = 2'd2
    } t_pos;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_RANGE = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        SG_ZERO = 2'd0,
        SG_POS  = 2'd1,
        SG_NEG  = 2'd2
    } t_sgn;

    // One cross request: sign of (a - o) x (b - o)
    typedef struct packed {
        logic                         start;
        logic signed [COORD_BITS-1:0] ox;
        logic signed [COORD_BITS-1:0] oy;
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
    } t_cx_req;

    typedef struct packed {
        logic done;
        t_sgn sgn;
    } t_cx_rsp;

endpackage

// File: hw/rtl/ich_if.sv
// Stream interfaces for the hull unit: command items in, result items out.
// Depends on ich_pkg.
interface ich_in_if import ich_pkg::*; ();
    logic                         valid;
    logic                         ready;
    t_kind                        kind;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic [VIDX_W-1:0]            vertex_index;

    modport source (output valid, kind, point_x, point_y, vertex_index, input ready);
    modport sink   (input valid, kind, point_x, point_y, vertex_index, output ready);
endinterface

interface ich_out_if import ich_pkg::*; ();
    logic                         valid;
    logic                         ready;
    t_pos                         position;
    logic [CNT_W-1:0]             vertex_count;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    t_err                         error;

    modport source (output valid, position, vertex_count, vertex_x, vertex_y, error,
                    input ready);
    modport sink   (input valid, position, vertex_count, vertex_x, vertex_y, error,
                    output ready);
endinterface

// File: hw/rtl/ich_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ich_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/ich_cross.sv
// Shared cross-product sign unit: one multiplier used twice per request.
// Depends on ich_pkg.
module ich_cross import ich_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cx_req i_req,
    output t_cx_rsp o_rsp
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    typedef enum logic [3:0] {
        CX_IDLE = 4'b0001,
        CX_M1   = 4'b0010,
        CX_M2   = 4'b0100,
        CX_CMP  = 4'b1000
    } t_cx_state;

    t_cx_state            r_state;
    logic signed [DW-1:0] r_dx1, r_dy1, r_dx2, r_dy2;
    logic signed [PW-1:0] r_p1, r_p2;
    logic                 r_done;
    t_sgn                 r_sgn;

    logic signed [DW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [PW:0]   cmp_d;
    t_sgn                 cmp_sgn;

    // share the multiplier between the two products
    always_comb begin
        mul_a = (r_state == CX_M1) ? r_dx1 : r_dy1;
        mul_b = (r_state == CX_M1) ? r_dy2 : r_dx2;
    end
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // sign of the difference of products
    always_comb begin
        cmp_d = (PW+1)'(r_p1) - (PW+1)'(r_p2);
        if (cmp_d == '0) begin
            cmp_sgn = SG_ZERO;
        end else if (cmp_d[PW]) begin
            cmp_sgn = SG_NEG;
        end else begin
            cmp_sgn = SG_POS;
        end
    end

    // step through differences, two products, compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CX_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                CX_IDLE: begin
                    if (i_req.start) begin
                        r_state <= CX_M1;
                    end
                end
                CX_M1:   r_state <= CX_M2;
                CX_M2:   r_state <= CX_CMP;
                CX_CMP: begin
                    r_done  <= 1'b1;
                    r_state <= CX_IDLE;
                end
                default: r_state <= CX_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == CX_IDLE && i_req.start) begin
            r_dx1 <= {i_req.ax[COORD_BITS-1], i_req.ax} - {i_req.ox[COORD_BITS-1], i_req.ox};
            r_dy1 <= {i_req.ay[COORD_BITS-1], i_req.ay} - {i_req.oy[COORD_BITS-1], i_req.oy};
            r_dx2 <= {i_req.bx[COORD_BITS-1], i_req.bx} - {i_req.ox[COORD_BITS-1], i_req.ox};
            r_dy2 <= {i_req.by[COORD_BITS-1], i_req.by} - {i_req.oy[COORD_BITS-1], i_req.oy};
        end
        if (r_state == CX_M1) begin
            r_p1 <= mul_p;
        end
        if (r_state == CX_M2) begin
            r_p2 <= mul_p;
        end
        if (r_state == CX_CMP) begin
            r_sgn <= cmp_sgn;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sgn  = r_sgn;
endmodule

// File: hw/rtl/incremental_convex_hull_unit.sv
// Incremental convex hull unit: sequencer, vertex RAM and shared cross unit.
// Depends on ich_pkg, ich_if, ich_ram and ich_cross.
//
// Usage: one command transfer on i_in (insert, locate, read vertex, clear)
// gives exactly one result transfer on o_out. i_in.ready is high only while
// the sequencer is idle; the result sits in an output register, so the next
// command can be taken while that result still waits on o_out.ready.
// Latency from the command transfer to a valid result, with n vertices:
//   clear and read use no cross product; locate: about 3 + log2 n cross
//   products; insert of an outside point: the locate, then n + 1 cross
//   products for the visibility walk and a RAM read and write per vertex
//   moved. The shared cross unit (one multiplier used for both products)
//   and the single read port of the vertex RAM set this latency.
// Reset (synchronous, active low) empties the polygon; the RAM is not
// cleared, since no entry at or beyond the vertex count is ever read.
// A stalled receiver holds the result; a finished second result waits
// in the sequencer until the output register frees up.
module incremental_convex_hull_unit import ich_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ich_in_if.sink    i_in,
    ich_out_if.source o_out
);
    localparam int CW = COORD_BITS;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_FO   = 14'b00000000000010,
        S_FA   = 14'b00000000000100,
        S_FR   = 14'b00000000001000,
        S_FW   = 14'b00000000010000,
        S_CW   = 14'b00000000100000,
        S_RD   = 14'b00000001000000,
        S_RDW  = 14'b00000010000000,
        S_VEND = 14'b00000100000000,
        S_MR   = 14'b00001000000000,
        S_MW   = 14'b00010000000000,
        S_WQ   = 14'b00100000000000,
        S_SW   = 14'b01000000000000,
        S_OUT  = 14'b10000000000000
    } t_state;

    typedef enum logic [6:0] {
        P_TRI   = 7'b0000001,
        P_C1    = 7'b0000010,
        P_CN    = 7'b0000100,
        P_BS    = 7'b0001000,
        P_EDGE  = 7'b0010000,
        P_VLAST = 7'b0100000,
        P_VIS   = 7'b1000000
    } t_phase;

    t_state               r_state;
    t_phase               r_phase;
    t_kind                r_kind;
    logic signed [CW-1:0] r_qx, r_qy, r_o_x, r_o_y, r_a_x, r_a_y;
    logic [VIDX_W-1:0]    r_idx;
    logic [CNT_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_fo_addr, r_fa_addr;
    t_sgn                 r_c1;
    logic [CNT_W-1:0]     r_lo, r_hi, r_mid;
    t_pos                 r_pos;
    t_err                 r_err;
    logic signed [CW-1:0] r_vx, r_vy;
    logic                 r_tri, r_swap;
    // visibility walk
    logic [CNT_W-1:0]     r_i, r_k, r_l0, r_s, r_m;
    logic                 r_prev, r_lead, r_found, r_run;
    // vertex mover
    logic [CNT_W-1:0]     r_src, r_dst, r_mcnt, r_qaddr, r_newcnt;
    logic                 r_up;
    // output register
    logic                 r_ov;
    t_pos                 r_out_pos;
    logic [CNT_W-1:0]     r_out_cnt;
    logic signed [CW-1:0] r_out_vx, r_out_vy;
    t_err                 r_out_err;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr, ram_raddr;
    logic [2*CW-1:0]      ram_wdata, ram_rdata;
    logic signed [CW-1:0] rd_x, rd_y;
    t_cx_req              cx_req;
    t_cx_rsp              cx_rsp;

    logic                 neg, box_hit, q_on_end;
    logic [CNT_W-1:0]     n_lo, n_hi, n_mid, n_clamp, n_last;
    logic [CNT_W:0]       mid_sum;
    logic                 loc_done;
    t_pos                 loc_pos;
    logic [CNT_W-1:0]     loc_seg;
    logic [CNT_W-1:0]     m_tot, wrap_e;
    logic [CNT_W:0]       new_n;
    logic                 wrap;

    assign rd_x = ram_rdata[CW-1:0];
    assign rd_y = ram_rdata[2*CW-1:CW];

    ich_ram #(.WIDTH(2 * CW), .DEPTH(MAX_VERTICES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ich_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cx_req),
        .o_rsp   (cx_rsp)
    );

    // RAM port selection per sequencer state
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_qaddr[IDX_W-1:0];
        ram_wdata = {r_qy, r_qx};
        ram_raddr = r_fo_addr;
        case (r_state)
            S_WQ: ram_we = 1'b1;
            S_MW: begin
                ram_we    = 1'b1;
                ram_waddr = r_dst[IDX_W-1:0];
                ram_wdata = ram_rdata;
            end
            S_SW: begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(2);
                ram_wdata = {r_a_y, r_a_x};
            end
            S_FA, S_FR: ram_raddr = r_fa_addr;
            S_RD:       ram_raddr = r_idx[IDX_W-1:0];
            S_MR:       ram_raddr = r_src[IDX_W-1:0];
            default:    ram_raddr = r_fo_addr;
        endcase
    end

    // cross request: o from register, a straight from RAM, b is the point
    always_comb begin
        cx_req.start = (r_state == S_FW);
        cx_req.ox    = r_o_x;
        cx_req.oy    = r_o_y;
        cx_req.ax    = rd_x;
        cx_req.ay    = rd_y;
        cx_req.bx    = r_qx;
        cx_req.by    = r_qy;
    end

    assign neg    = (cx_rsp.sgn == SG_NEG);
    assign n_last = r_count - CNT_W'(1);

    // point inside the bounding box of edge o-a, and point equal to an end
    always_comb begin
        box_hit = ((r_qx >= r_o_x && r_qx <= r_a_x) || (r_qx >= r_a_x && r_qx <= r_o_x)) &&
                  ((r_qy >= r_o_y && r_qy <= r_a_y) || (r_qy >= r_a_y && r_qy <= r_o_y));
        q_on_end = (r_qx == r_o_x && r_qy == r_o_y) || (r_qx == r_a_x && r_qy == r_a_y);
    end

    // binary search step by angle around vertex 0
    always_comb begin
        if (!neg) begin
            n_lo = r_mid;
            n_hi = r_hi;
        end else begin
            n_lo = r_lo;
            n_hi = r_mid - CNT_W'(1);
        end
        mid_sum = {1'b0, n_lo} + {1'b0, n_hi} + (CNT_W+1)'(1);
        n_mid   = mid_sum[CNT_W:1];
        if (n_lo < CNT_W'(1)) begin
            n_clamp = CNT_W'(1);
        end else if (n_lo > r_count - CNT_W'(2)) begin
            n_clamp = r_count - CNT_W'(2);
        end else begin
            n_clamp = n_lo;
        end
    end

    // locate outcome once a deciding cross product is back
    always_comb begin
        loc_done = 1'b0;
        loc_pos  = POS_OUTSIDE;
        loc_seg  = r_lo;
        case (r_phase)
            P_C1: begin
                if (cx_rsp.sgn == SG_ZERO && box_hit) begin
                    loc_done = 1'b1;
                    loc_pos  = POS_BORDER;
                    loc_seg  = '0;
                end
            end
            P_CN: begin
                if (cx_rsp.sgn == SG_ZERO && box_hit) begin
                    loc_done = 1'b1;
                    loc_pos  = POS_BORDER;
                    loc_seg  = n_last;
                end else if (r_c1 != SG_POS || !neg) begin
                    loc_done = 1'b1;
                end
            end
            P_EDGE: begin
                loc_done = 1'b1;
                if (cx_rsp.sgn == SG_POS) begin
                    loc_pos = POS_INSIDE;
                end else if (cx_rsp.sgn == SG_ZERO) begin
                    loc_pos = POS_BORDER;
                end
            end
            default: loc_done = 1'b0;
        endcase
    end

    // visible run summary after the walk
    always_comb begin
        m_tot  = r_run ? (r_m + r_l0) : r_m;
        new_n  = {1'b0, r_count} - {1'b0, m_tot} + (CNT_W+1)'(2);
        wrap   = ({1'b0, r_s} + {1'b0, m_tot}) > {1'b0, r_count};
        wrap_e = r_s + m_tot - r_count;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= P_C1;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_tri   <= 1'b0;
            r_swap  <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_kind <= i_in.kind;
                        r_qx   <= i_in.point_x;
                        r_qy   <= i_in.point_y;
                        r_idx  <= i_in.vertex_index;
                        r_pos  <= POS_INSIDE;
                        r_err  <= ERR_NONE;
                        r_vx   <= '0;
                        r_vy   <= '0;
                        r_swap <= 1'b0;
                        r_tri  <= 1'b0;
                        case (i_in.kind)
                            K_INSERT, K_LOCATE: begin
                                if (r_count < CNT_W'(3)) begin
                                    r_pos <= POS_OUTSIDE;
                                    if (i_in.kind == K_INSERT) begin
                                        r_qaddr  <= r_count;
                                        r_newcnt <= r_count + CNT_W'(1);
                                        r_tri    <= (r_count == CNT_W'(2));
                                        r_state  <= S_WQ;
                                    end else begin
                                        r_state <= S_OUT;
                                    end
                                end else begin
                                    r_fo_addr <= '0;
                                    r_fa_addr <= IDX_W'(1);
                                    r_phase   <= P_C1;
                                    r_state   <= S_FO;
                                end
                            end
                            K_READ: begin
                                if (CNT_W'(i_in.vertex_index) < r_count) begin
                                    r_state <= S_RD;
                                end else begin
                                    r_err   <= ERR_RANGE;
                                    r_state <= S_OUT;
                                end
                            end
                            default: begin
                                r_count <= '0;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                // fetch o then a, then start the cross unit
                S_FO: r_state <= S_FA;
                S_FA: begin
                    r_o_x   <= rd_x;
                    r_o_y   <= rd_y;
                    r_state <= S_FW;
                end
                S_FR: begin
                    r_o_x   <= r_a_x;
                    r_o_y   <= r_a_y;
                    r_state <= S_FW;
                end
                S_FW: begin
                    r_a_x   <= rd_x;
                    r_a_y   <= rd_y;
                    r_state <= S_CW;
                end
                S_CW: begin
                    if (cx_rsp.done) begin
                        if (loc_done && loc_pos == POS_BORDER) begin
                            r_pos <= POS_BORDER;
                            if (r_kind != K_INSERT || q_on_end) begin
                                r_state <= S_OUT;
                            end else if (r_count >= CNT_W'(MAX_VERTICES)) begin
                                r_err   <= ERR_FULL;
                                r_state <= S_OUT;
                            end else begin
                                // open a slot after the edge start
                                r_up     <= 1'b0;
                                r_src    <= n_last;
                                r_dst    <= r_count;
                                r_mcnt   <= n_last - loc_seg;
                                r_qaddr  <= loc_seg + CNT_W'(1);
                                r_newcnt <= r_count + CNT_W'(1);
                                r_state  <= (n_last == loc_seg) ? S_WQ : S_MR;
                            end
                        end else if (loc_done && loc_pos == POS_INSIDE) begin
                            r_pos   <= POS_INSIDE;
                            r_state <= S_OUT;
                        end else if (loc_done) begin
                            r_pos <= POS_OUTSIDE;
                            if (r_kind != K_INSERT) begin
                                r_state <= S_OUT;
                            end else begin
                                r_fo_addr <= n_last[IDX_W-1:0];
                                r_fa_addr <= '0;
                                r_phase   <= P_VLAST;
                                r_state   <= S_FO;
                            end
                        end else begin
                            case (r_phase)
                                P_TRI: begin
                                    if (neg) begin
                                        r_qaddr <= CNT_W'(1);
                                        r_swap  <= 1'b1;
                                        r_state <= S_WQ;
                                    end else begin
                                        r_state <= S_OUT;
                                    end
                                end
                                P_C1: begin
                                    r_c1      <= cx_rsp.sgn;
                                    r_fo_addr <= '0;
                                    r_fa_addr <= n_last[IDX_W-1:0];
                                    r_phase   <= P_CN;
                                    r_state   <= S_FO;
                                end
                                P_CN: begin
                                    r_lo      <= '0;
                                    r_hi      <= n_last;
                                    r_mid     <= r_count >> 1;
                                    r_fo_addr <= '0;
                                    r_fa_addr <= r_count[IDX_W:1];
                                    r_phase   <= P_BS;
                                    r_state   <= S_FO;
                                end
                                P_BS: begin
                                    r_lo      <= n_lo;
                                    r_hi      <= n_hi;
                                    r_fo_addr <= '0;
                                    r_state   <= S_FO;
                                    if (n_lo < n_hi) begin
                                        r_mid     <= n_mid;
                                        r_fa_addr <= n_mid[IDX_W-1:0];
                                    end else begin
                                        r_lo      <= n_clamp;
                                        r_fo_addr <= n_clamp[IDX_W-1:0];
                                        r_fa_addr <= IDX_W'(n_clamp + CNT_W'(1));
                                        r_phase   <= P_EDGE;
                                    end
                                end
                                P_VLAST: begin
                                    r_prev    <= neg;
                                    r_i       <= '0;
                                    r_k       <= '0;
                                    r_l0      <= '0;
                                    r_lead    <= 1'b1;
                                    r_found   <= 1'b0;
                                    r_run     <= 1'b0;
                                    r_s       <= '0;
                                    r_m       <= '0;
                                    r_fo_addr <= '0;
                                    r_fa_addr <= IDX_W'(1);
                                    r_phase   <= P_VIS;
                                    r_state   <= S_FO;
                                end
                                P_VIS: begin
                                    // track visible count, leading run, first run
                                    r_k <= r_k + CNT_W'(neg);
                                    if (r_lead) begin
                                        if (neg) begin
                                            r_l0 <= r_l0 + CNT_W'(1);
                                        end else begin
                                            r_lead <= 1'b0;
                                        end
                                    end
                                    if (!r_found && neg && !r_prev) begin
                                        r_found <= 1'b1;
                                        r_s     <= r_i;
                                        r_m     <= CNT_W'(1);
                                        r_run   <= 1'b1;
                                    end else if (r_run) begin
                                        if (neg) begin
                                            r_m <= r_m + CNT_W'(1);
                                        end else begin
                                            r_run <= 1'b0;
                                        end
                                    end
                                    r_prev <= neg;
                                    if (r_i == n_last) begin
                                        r_state <= S_VEND;
                                    end else begin
                                        r_i <= r_i + CNT_W'(1);
                                        if (r_i + CNT_W'(2) == r_count) begin
                                            r_fa_addr <= '0;
                                        end else begin
                                            r_fa_addr <= IDX_W'(r_i + CNT_W'(2));
                                        end
                                        r_state <= S_FR;
                                    end
                                end
                                default: r_state <= S_OUT;
                            endcase
                        end
                    end
                end
                // replace the visible run by the new point
                S_VEND: begin
                    if (r_k == '0 || r_k == r_count) begin
                        r_state <= S_OUT;
                    end else if (new_n > (CNT_W+1)'(MAX_VERTICES)) begin
                        r_err   <= ERR_FULL;
                        r_state <= S_OUT;
                    end else begin
                        r_newcnt <= new_n[CNT_W-1:0];
                        if (wrap) begin
                            r_up    <= 1'b1;
                            r_src   <= wrap_e;
                            r_dst   <= CNT_W'(1);
                            r_mcnt  <= r_s - wrap_e + CNT_W'(1);
                            r_qaddr <= '0;
                            r_state <= (r_s - wrap_e + CNT_W'(1) == '0) ? S_WQ : S_MR;
                        end else if (m_tot == CNT_W'(1)) begin
                            r_up    <= 1'b0;
                            r_src   <= n_last;
                            r_dst   <= r_count;
                            r_mcnt  <= n_last - r_s;
                            r_qaddr <= r_s + CNT_W'(1);
                            r_state <= (n_last == r_s) ? S_WQ : S_MR;
                        end else begin
                            r_up    <= 1'b1;
                            r_src   <= r_s + m_tot;
                            r_dst   <= r_s + CNT_W'(2);
                            r_mcnt  <= r_count - r_s - m_tot;
                            r_qaddr <= r_s + CNT_W'(1);
                            r_state <= (r_count == r_s + m_tot) ? S_WQ : S_MR;
                        end
                    end
                end
                S_MR: r_state <= S_MW;
                S_MW: begin
                    if (r_up) begin
                        r_src <= r_src + CNT_W'(1);
                        r_dst <= r_dst + CNT_W'(1);
                    end else begin
                        r_src <= r_src - CNT_W'(1);
                        r_dst <= r_dst - CNT_W'(1);
                    end
                    r_mcnt  <= r_mcnt - CNT_W'(1);
                    r_state <= (r_mcnt == CNT_W'(1)) ? S_WQ : S_MR;
                end
                S_WQ: begin
                    r_count <= r_newcnt;
                    if (r_swap) begin
                        r_state <= S_SW;
                    end else if (r_tri) begin
                        r_tri     <= 1'b0;
                        r_fo_addr <= '0;
                        r_fa_addr <= IDX_W'(1);
                        r_phase   <= P_TRI;
                        r_state   <= S_FO;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_SW: r_state <= S_OUT;
                S_RD: r_state <= S_RDW;
                S_RDW: begin
                    r_vx    <= rd_x;
                    r_vy    <= rd_y;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hand the result over once the output register is free
                    if (!r_ov || o_out.ready) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ov || o_out.ready)) begin
            r_out_pos <= r_pos;
            r_out_cnt <= r_count;
            r_out_vx  <= r_vx;
            r_out_vy  <= r_vy;
            r_out_err <= r_err;
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ov;
    assign o_out.position     = r_out_pos;
    assign o_out.vertex_count = r_out_cnt;
    assign o_out.vertex_x     = r_out_vx;
    assign o_out.vertex_y     = r_out_vy;
    assign o_out.error        = r_out_err;

    // one command at a time: no transfer right after a transfer
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("command taken while busy");

    // vertex count stays within the store
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond store");

    // failed read carries zero coordinates
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.error == ERR_RANGE) |->
            (o_out.vertex_x == '0 && o_out.vertex_y == '0))
        else $error("failed read with nonzero vertex");

    // cross unit cannot answer in the cycle after a request
    a_cx_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cx_req.start |=> !cx_rsp.done)
        else $error("cross result too early");
endmodule
